>>> design/demf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package demf_pkg;

	localparam int unsigned DEF_CAPACITY = 8;

	localparam int unsigned SENSOR_W  = 8;
	localparam int unsigned REV_W     = 32;
	localparam int unsigned EDGE_W    = 2;
	localparam int unsigned OUTC_W    = 8;
	localparam int unsigned ENTRY_W   = SENSOR_W + REV_W + EDGE_W + OUTC_W;
	localparam int unsigned OVF_W     = 32;
	localparam int unsigned IN_DATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int unsigned IN_USER_W = 3;
	localparam int unsigned STATUS_W  = 3;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_VIEW = 2'd2,
		ACT_TAKE = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_INVALID   = 3'd3,
		ST_POPPED    = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_VIEW      = 3'd6,
		ST_TAKE      = 3'd7
	} status_t;

	typedef struct packed {
		logic vld;
		logic hit;
	} match_t;

endpackage

`default_nettype wire

>>> design/demf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module demf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/demf_match.sv
`timescale 1ns / 1ps
`default_nettype none

module demf_match
	import demf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_vld,
	input  wire logic [ENTRY_W-1:0] rd_data,
	input  wire logic [ENTRY_W-1:0] ev,
	output match_t                  match_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2 <= '0;
		end else begin
			match_s2.vld <= rd_vld;
			match_s2.hit <= rd_vld && (rd_data == ev);
		end
	end

endmodule

`default_nettype wire

>>> design/dedup_event_mailbox_fifo_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Event mailbox: a ring of CAPACITY alarm events held in one RAM with a single
// read port. Each request gives exactly one response. A valid push compares the
// event against every pending entry through one shared compare stage, reading
// one entry a cycle. A pop reads the head entry of the ring. A view, a take, a
// pop from an empty ring, an invalid push or a push into an empty ring reads
// no entry. A response that the receiver has not yet taken holds the block in
// its done state. The block accepts one request at a time and takes the next
// once the response sits in the output register.
// The RAM needs no clearing after reset: only pending entries are ever read.
module dedup_event_mailbox_fifo_core
	import demf_pkg::*;
#(
	parameter int unsigned CAPACITY = DEF_CAPACITY,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1),
	localparam int unsigned OUT_BITS = ENTRY_W + OVF_W + CNT_W + 2,
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// sensor, revision, edge code, outcome code, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action, event_valid
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// popped sensor, popped revision, popped edge, popped outcome,
	// overflow_total, occupancy, overflow_flag, log_flag, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// status
	output logic [STATUS_W-1:0]        m_axis_tuser
);

	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_POP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	action_t             act_q;
	logic                valid_q;
	logic [ENTRY_W-1:0]  ev_q;
	logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0]    scan_addr_q;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [CNT_W-1:0]    issued_q;
	logic [CNT_W-1:0]    checked_q;
	logic                dup_q;
	logic [OVF_W-1:0]    ovf_q, ovf_d;
	logic                latch_q, latch_d;
	logic                log_q, log_d;
	logic                log_rep;
	logic                rd_vld_s1;
	logic                out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0] out_user_q;

	logic                ram_re;
	logic                ram_we;
	logic [PTR_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	match_t              match_s2;

	logic                accept;
	logic                out_free;
	logic                load;
	status_t             status_d;
	logic [ENTRY_W-1:0]  resp_entry;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	demf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (ev_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	demf_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_vld   (rd_vld_s1),
		.rd_data  (ram_rdata),
		.ev       (ev_q),
		.match_s2 (match_s2)
	);

	always_comb begin
		state_d    = state_q;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_raddr  = rd_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		fill_d     = fill_q;
		ovf_d      = ovf_q;
		latch_d    = latch_q;
		log_d      = log_q;
		load       = 1'b0;
		status_d   = ST_VIEW;
		resp_entry = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					if ((action_t'(s_axis_tuser[1:0]) == ACT_PUSH) && s_axis_tuser[2] &&
					    (fill_q != '0)) begin
						state_d = S_SCAN;
					end else if ((action_t'(s_axis_tuser[1:0]) == ACT_POP) &&
					             (fill_q != '0)) begin
						state_d = S_POP;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (issued_q < fill_q) begin
					ram_re    = 1'b1;
					ram_raddr = scan_addr_q;
				end
				if (checked_q == fill_q) begin
					state_d = S_DONE;
				end
			end
			S_POP: begin
				ram_re    = 1'b1;
				ram_raddr = rd_ptr_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					unique case (act_q)
						ACT_PUSH: begin
							if (!valid_q) begin
								status_d = ST_INVALID;
							end else if (dup_q) begin
								status_d = ST_DUPLICATE;
							end else if (fill_q == FULL_CNT) begin
								status_d = ST_FULL;
								if (ovf_q != '1) begin
									ovf_d = ovf_q + 1'b1;
								end
								if (!latch_q) begin
									latch_d = 1'b1;
									log_d   = 1'b1;
								end
							end else begin
								status_d = ST_ACCEPTED;
								ram_we   = 1'b1;
								wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
								fill_d   = fill_q + 1'b1;
							end
						end
						ACT_POP: begin
							if (fill_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								status_d   = ST_POPPED;
								resp_entry = ram_rdata;
								rd_ptr_d   = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
								fill_d     = fill_q - 1'b1;
							end
						end
						ACT_VIEW: begin
							status_d = ST_VIEW;
						end
						ACT_TAKE: begin
							status_d = ST_TAKE;
							log_d    = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		log_rep = (act_q == ACT_TAKE) ? log_q : log_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			scan_addr_q <= '0;
			fill_q      <= '0;
			issued_q    <= '0;
			checked_q   <= '0;
			dup_q       <= 1'b0;
			ovf_q       <= '0;
			latch_q     <= 1'b0;
			log_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			fill_q    <= fill_d;
			ovf_q     <= ovf_d;
			latch_q   <= latch_d;
			log_q     <= log_d;
			rd_vld_s1 <= ram_re && (state_q == S_SCAN);
			if (accept) begin
				scan_addr_q <= rd_ptr_q;
				issued_q    <= '0;
				checked_q   <= '0;
				dup_q       <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (ram_re) begin
					issued_q    <= issued_q + 1'b1;
					scan_addr_q <= (scan_addr_q == LAST_IDX) ? '0 : scan_addr_q + 1'b1;
				end
				if (match_s2.vld) begin
					checked_q <= checked_q + 1'b1;
					dup_q     <= dup_q | match_s2.hit;
				end
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// hold the request and the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action_t'(s_axis_tuser[1:0]);
			valid_q <= s_axis_tuser[2];
			ev_q    <= s_axis_tdata[ENTRY_W-1:0];
		end
		if (load) begin
			out_data_q <= OUT_DATA_W'({log_rep, latch_d, fill_d, ovf_d, resp_entry});
			out_user_q <= status_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("occupancy above capacity");

	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && state_d == S_DONE) |-> (!rd_vld_s1 && !match_s2.vld))
		else $error("scan closed with a read in flight");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && status_d == ST_ACCEPTED) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("accepted push did not grow occupancy");

	a_ovf_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (ovf_q >= $past(ovf_q)))
		else $error("overflow counter went down");

	a_log_needs_latch: assert property (@(posedge clk) disable iff (!arst_n)
		log_q |-> latch_q)
		else $error("log pending without overflow latch");

endmodule

`default_nettype wire
